[sv/box_drawing_grid_merger_assert.svh]
// Assertion macros used by the checker file of the grid merger.
`ifndef BOX_DRAWING_GRID_MERGER_ASSERT_SVH
`define BOX_DRAWING_GRID_MERGER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define BDGM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BDGM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[sv/bdgm_pkg.sv]
// Package with the shared types, constants and glyph tables of the grid merger.
package bdgm_pkg;
    localparam int DefMaxRows = 64;
    localparam int DefMaxCols = 128;
    localparam int BudgetW = 14;
    localparam logic [BudgetW-1:0] BudgetReset = 14'd8192;

    localparam logic [2:0] CMD_PUT = 3'd0;
    localparam logic [2:0] CMD_HLINE = 3'd1;
    localparam logic [2:0] CMD_VLINE = 3'd2;
    localparam logic [2:0] CMD_BOX = 3'd3;
    localparam logic [2:0] CMD_ARROW = 3'd4;
    localparam logic [2:0] CMD_READ = 3'd5;

    localparam logic [3:0] ARM_U = 4'd1;
    localparam logic [3:0] ARM_D = 4'd2;
    localparam logic [3:0] ARM_L = 4'd4;
    localparam logic [3:0] ARM_R = 4'd8;

    localparam logic [15:0] GLYPH_SPACE = 16'h0020;

    // Arms implied by a line glyph that was put as plain text.
    function automatic logic [3:0] arms_of_glyph(input logic [15:0] g);
        logic [3:0] a;
        case (g)
            16'h2500: a = ARM_L | ARM_R;
            16'h2502, 16'h2551: a = ARM_U | ARM_D;
            16'h250C: a = ARM_D | ARM_R;
            16'h2510: a = ARM_D | ARM_L;
            16'h2514: a = ARM_U | ARM_R;
            16'h2518: a = ARM_U | ARM_L;
            16'h251C: a = ARM_U | ARM_D | ARM_R;
            16'h2524: a = ARM_U | ARM_D | ARM_L;
            16'h252C: a = ARM_D | ARM_L | ARM_R;
            16'h2534: a = ARM_U | ARM_L | ARM_R;
            16'h253C: a = 4'hF;
            default: a = 4'h0;
        endcase
        return a;
    endfunction

    // Junction glyph for a set of arms.
    function automatic logic [15:0] glyph_of_arms(input logic [3:0] a, input logic dbl);
        logic [15:0] g;
        case (a)
            4'd4, 4'd8, 4'd12: g = 16'h2500;
            4'd1, 4'd2, 4'd3: g = dbl ? 16'h2551 : 16'h2502;
            4'd10: g = 16'h250C;
            4'd6: g = 16'h2510;
            4'd9: g = 16'h2514;
            4'd5: g = 16'h2518;
            4'd11: g = 16'h251C;
            4'd7: g = 16'h2524;
            4'd14: g = 16'h252C;
            4'd13: g = 16'h2534;
            4'd15: g = 16'h253C;
            default: g = GLYPH_SPACE;
        endcase
        return g;
    endfunction

    function automatic logic [15:0] arrow_glyph(input logic [1:0] d);
        logic [15:0] g;
        case (d)
            2'd0: g = 16'h25B2;
            2'd1: g = 16'h25BC;
            2'd2: g = 16'h25C4;
            default: g = 16'h25BA;
        endcase
        return g;
    endfunction

    // One cell operation handed from the sequencer to the cell engine.
    typedef struct packed {
        logic        put;
        logic [11:0] row;
        logic [11:0] col;
        logic [3:0]  arms;
        logic        dbl;
        logic [15:0] glyph;
    } t_cell_op;
endpackage

[sv/bdgm_cell_engine.sv]
// Cell engine: grows the grid and does one read-modify-write on the cell memory.
module bdgm_cell_engine import bdgm_pkg::*; #(
    parameter int MAX_ROWS = DefMaxRows,
    parameter int MAX_COLS = DefMaxCols,
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int LW = $clog2(MAX_COLS + 1),
    localparam int UW = $clog2(MAX_ROWS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_cell_op           i_op,
    input  logic               i_rd,
    input  logic [BudgetW-1:0] i_budget,
    output logic               o_ready,
    output logic               o_done,
    output logic               o_ok,
    output logic [15:0]        o_rd_glyph,
    output logic               o_rd_present,
    output logic [UW-1:0]      o_used_rows,
    output logic [LW-1:0]      o_widest
);
    localparam int AW = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int LDEPTH = 1 << RW;
    localparam logic [1:0] S_IDLE = 2'd0, S_LEN = 2'd1, S_MEM = 2'd2, S_WB = 2'd3;

    // Cell memory and row length memory, both cleared by a pass after reset.
    logic [20:0]   cell_mem [DEPTH];
    logic [LW-1:0] len_mem [LDEPTH];

    logic [1:0] r_st, n_st;
    t_cell_op r_op;
    logic r_rd;
    logic [LW-1:0] r_len;
    logic [20:0] r_cell;
    logic r_in;
    logic [UW-1:0] r_used;
    logic [BudgetW:0] r_cells;
    logic [LW-1:0] r_wide;
    logic [AW-1:0] r_addr;
    logic r_done, r_ok;
    logic [15:0] r_rg;
    logic r_rp;
    // Clearing pass: one entry of each memory per cycle after reset.
    logic r_clr;
    logic [AW-1:0] r_clr_addr;

    logic signed [11:0] srow, scol;
    assign srow = r_op.row;
    assign scol = r_op.col;
    logic inrange;
    assign inrange = !srow[11] && !scol[11] && (int'(srow) < MAX_ROWS)
        && (int'(scol) < MAX_COLS);
    logic [RW-1:0] ridx;
    logic [CW-1:0] cidx;
    assign ridx = r_op.row[RW-1:0];
    assign cidx = r_op.col[CW-1:0];

    // Length of the target row, zero past the used rows.
    logic [LW-1:0] have, need;
    logic row_exists;
    assign row_exists = ({{(12-RW){1'b0}}, ridx} < 12'(r_used));
    assign have = row_exists ? r_len : '0;
    assign need = LW'({1'b0, cidx}) + LW'(1);
    logic grows;
    logic [BudgetW:0] new_cells;
    assign grows = need > have;
    assign new_cells = r_cells + (BudgetW+1)'(need - have);
    logic fits;
    assign fits = !grows || (new_cells <= {1'b0, i_budget});
    logic present;
    assign present = r_in && row_exists && (LW'({1'b0, cidx}) < r_len);

    // Double bit 20, arms 19:16, glyph 15:0.
    logic [15:0] old_g;
    logic [3:0] old_a, cur, m;
    logic old_d, text, dblv;
    assign old_g = r_cell[15:0];
    assign old_a = r_cell[19:16];
    assign old_d = r_cell[20];
    assign cur = (old_a == 4'h0) ? arms_of_glyph(old_g) : old_a;
    assign text = (cur == 4'h0) && (old_g != GLYPH_SPACE);
    assign m = cur | r_op.arms;
    assign dblv = old_d | r_op.dbl;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_start && !r_clr) n_st = S_LEN;
            S_LEN: n_st = S_MEM;
            S_MEM: n_st = S_WB;
            S_WB: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_used <= '0;
            r_cells <= '0;
            r_wide <= '0;
            r_done <= 1'b0;
            r_clr <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_st <= n_st;
            r_done <= (r_st == S_WB);
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (&r_clr_addr) r_clr <= 1'b0;
            end
            if (r_st == S_IDLE && i_start) begin
                r_op <= i_op;
                r_rd <= i_rd;
            end
            if (r_st == S_LEN) begin
                r_addr <= {ridx, cidx};
                r_in <= inrange;
            end
            // Decide and commit in the write-back cycle.
            if (r_st == S_WB) begin
                r_rp <= r_rd && present;
                r_rg <= (r_rd && present) ? old_g : 16'h0000;
                r_ok <= r_rd ? present : (r_in && fits);
                if (!r_rd && r_in && fits) begin
                    if (!row_exists) r_used <= UW'({1'b0, ridx}) + UW'(1);
                    if (grows) begin
                        r_cells <= new_cells;
                        if (need > r_wide) r_wide <= need;
                    end
                end
            end
        end
    end

    // Row length memory: read in the first cycle, written back on growth.
    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_start) begin
            r_len <= len_mem[i_op.row[RW-1:0]];
        end
        if (r_clr) len_mem[r_clr_addr[RW-1:0]] <= '0;
        else if (r_st == S_WB && !r_rd && r_in && fits && grows) len_mem[ridx] <= need;
    end

    // Cell memory: registered read in S_MEM, then written back in S_WB.
    always_ff @(posedge i_clk) begin
        if (r_st == S_MEM) r_cell <= cell_mem[r_addr];
        if (r_clr) begin
            cell_mem[r_clr_addr] <= {1'b0, 4'h0, GLYPH_SPACE};
        end else if (r_st == S_WB && !r_rd && r_in && fits) begin
            if (r_op.put)
                cell_mem[r_addr] <= {1'b0, 4'h0, r_op.glyph};
            else if (!text)
                cell_mem[r_addr] <= {dblv, m, glyph_of_arms(m, dblv)};
        end
    end

    // Rows past the used count read as zero length through row_exists.
    assign o_ready = !r_clr;
    assign o_done = r_done;
    assign o_ok = r_ok;
    assign o_rd_glyph = r_rg;
    assign o_rd_present = r_rp;
    assign o_used_rows = r_used;
    assign o_widest = r_wide;
endmodule

[sv/box_drawing_grid_merger.sv]
// Top level of the box-drawing grid merger: command sequencer and stream ports.
// After reset the cell engine clears both of its memories in a pass of one entry
// per cycle, and no word is taken until it ends. Each command then becomes a run
// of single-cell operations on the cell memory's one port, each stepping through
// issue with the row length read, range check, cell read, write-back, and the
// cycle in which the sequencer sees completion. A result word follows the last of
// its n cell operations, and the next command word can be taken in the cycle in
// which that result word appears, or later while the previous result still waits.
// A put, arrowhead or read has n = 1; a line of n cells has n (fewer when a
// horizontal line is cut short); a box w columns wide and h rows high has 2w+2h,
// or w when it is one row high (fewer when a row is cut short); an unused command
// code gives its result without any cell operation.
module box_drawing_grid_merger import bdgm_pkg::*; #(
    parameter int MAX_ROWS = DefMaxRows,
    parameter int MAX_COLS = DefMaxCols
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // command[2:0], row[14:3], col[26:15], row_end[38:27], col_end[50:39],
    // glyph[66:51], double_walls[67], direction[69:68], zero pad to 72
    input  logic [71:0]        s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // accepted[0], read_glyph[16:1], cell_present[17], line_count[24:18],
    // widest_line[32:25], zero pad to 40
    output logic [39:0]        m_axis_tdata,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [BudgetW-1:0] i_cfg_data
);
    localparam int LW = $clog2(MAX_COLS + 1);
    localparam int UW = $clog2(MAX_ROWS + 1);
    localparam logic [1:0] S_IDLE = 2'd0, S_ISSUE = 2'd1, S_WAIT = 2'd2, S_OUT = 2'd3;
    // Phases of a box, and P_LINE for the other commands.
    localparam logic [2:0] P_TOP = 3'd0, P_BOT = 3'd1, P_CORN = 3'd2, P_SIDE = 3'd3,
        P_FOOT = 3'd4, P_LINE = 3'd5;

    logic [BudgetW-1:0] r_budget;
    logic [1:0] r_st;
    logic [2:0] r_cmd, r_ph;
    logic signed [11:0] r_top, r_bot, r_lft, r_rgt, r_pos, r_fix;
    logic r_dw, r_side2, r_first, r_acc, r_hv;
    t_cell_op r_op;
    logic r_rd;
    logic [39:0] r_out;
    logic r_ovalid;

    logic e_ready, e_done, e_ok, e_rp;
    logic [15:0] e_rg;
    logic [UW-1:0] e_used;
    logic [LW-1:0] e_wide;

    bdgm_cell_engine #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_eng (
        .i_clk, .i_rst_n, .i_start(r_st == S_ISSUE), .i_op(r_op), .i_rd(r_rd),
        .i_budget(r_budget), .o_ready(e_ready), .o_done(e_done), .o_ok(e_ok),
        .o_rd_glyph(e_rg), .o_rd_present(e_rp), .o_used_rows(e_used),
        .o_widest(e_wide));

    assign o_cfg_ready = 1'b1;
    assign s_axis_tready = (r_st == S_IDLE) && e_ready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_out;

    logic signed [11:0] i_row, i_col, i_re, i_ce;
    assign i_row = s_axis_tdata[14:3];
    assign i_col = s_axis_tdata[26:15];
    assign i_re = s_axis_tdata[38:27];
    assign i_ce = s_axis_tdata[50:39];

    // Ordered ends of the incoming command.
    logic [2:0] w_cmd;
    logic signed [11:0] w_top, w_bot, w_lft, w_rgt;
    assign w_cmd = s_axis_tdata[2:0];
    assign w_top = (i_re < i_row) ? i_re : i_row;
    assign w_bot = (i_re < i_row) ? i_row : i_re;
    assign w_lft = (i_ce < i_col) ? i_ce : i_col;
    assign w_rgt = (i_ce < i_col) ? i_col : i_ce;

    // Helper that fills an op.
    function automatic t_cell_op mk(input logic signed [11:0] r, input logic signed [11:0] c,
                                    input logic [3:0] a, input logic d);
        t_cell_op o;
        o.put = 1'b0; o.row = r; o.col = c; o.arms = a; o.dbl = d; o.glyph = '0;
        return o;
    endfunction

    // Arms of a line cell at position p between lo and hi, horizontal or vertical.
    function automatic logic [3:0] line_arms(input logic h, input logic signed [11:0] p,
                                             input logic signed [11:0] lo,
                                             input logic signed [11:0] hi);
        logic [3:0] a;
        if (lo == hi) a = h ? (ARM_L | ARM_R) : (ARM_U | ARM_D);
        else if (p == lo) a = h ? ARM_R : ARM_D;
        else if (p == hi) a = h ? ARM_L : ARM_U;
        else a = h ? (ARM_L | ARM_R) : (ARM_U | ARM_D);
        return a;
    endfunction

    // First cell operation of the incoming command.
    t_cell_op w_op;
    always_comb begin
        w_op = mk(i_row, i_col, 4'h0, 1'b0);
        case (w_cmd)
            CMD_HLINE: w_op = mk(i_row, w_lft,
                (i_ce == i_col) ? (ARM_L | ARM_R) : ARM_R, 1'b0);
            CMD_VLINE: w_op = mk(w_top, i_col,
                (i_re == i_row) ? (ARM_U | ARM_D) : ARM_D, 1'b0);
            CMD_BOX: w_op = mk(w_top, w_lft,
                (i_ce == i_col) ? (ARM_L | ARM_R) : ARM_R, 1'b0);
            default: begin
                w_op.put = 1'b1;
                w_op.glyph = (w_cmd == CMD_ARROW) ? arrow_glyph(s_axis_tdata[69:68])
                    : s_axis_tdata[66:51];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= BudgetReset;
            r_st <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_budget <= i_cfg_data;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (s_axis_tvalid && e_ready) begin
                    r_cmd <= w_cmd;
                    r_dw <= s_axis_tdata[67];
                    r_first <= 1'b1;
                    r_acc <= 1'b0;
                    r_rd <= (w_cmd == CMD_READ);
                    r_side2 <= 1'b0;
                    r_hv <= (w_cmd != CMD_VLINE);
                    r_top <= w_top;
                    r_bot <= w_bot;
                    r_lft <= w_lft;
                    r_rgt <= w_rgt;
                    r_fix <= (w_cmd == CMD_VLINE) ? i_col
                        : ((w_cmd == CMD_BOX) ? w_top : i_row);
                    r_pos <= (w_cmd == CMD_VLINE) ? w_top : w_lft;
                    r_ph <= (w_cmd == CMD_BOX) ? P_TOP : P_LINE;
                    r_op <= w_op;
                    r_st <= (w_cmd > CMD_READ) ? S_OUT : S_ISSUE;
                end
                S_ISSUE: r_st <= S_WAIT;
                S_WAIT: if (e_done) begin
                    r_first <= 1'b0;
                    if (r_first) r_acc <= e_ok;
                    if (r_cmd == CMD_PUT || r_cmd == CMD_ARROW || r_cmd == CMD_READ
                        || (r_cmd == CMD_VLINE && r_pos >= r_bot)
                        || (r_cmd == CMD_HLINE && (r_pos >= r_rgt || !e_ok))) begin
                        r_st <= S_OUT;
                    end else if (r_cmd == CMD_HLINE || r_cmd == CMD_VLINE) begin
                        r_st <= S_ISSUE;
                        r_pos <= r_pos + 12'sd1;
                        r_op <= r_hv
                            ? mk(r_fix, r_pos + 12'sd1,
                                 line_arms(1'b1, r_pos + 12'sd1, r_lft, r_rgt), 1'b0)
                            : mk(r_pos + 12'sd1, r_fix,
                                 line_arms(1'b0, r_pos + 12'sd1, r_top, r_bot), 1'b0);
                    end else begin
                        // Box sequencing.
                        case (r_ph)
                            P_TOP, P_BOT: begin
                                if (r_pos < r_rgt && e_ok) begin
                                    r_st <= S_ISSUE;
                                    r_pos <= r_pos + 12'sd1;
                                    r_op <= mk(r_fix, r_pos + 12'sd1,
                                        line_arms(1'b1, r_pos + 12'sd1, r_lft, r_rgt), 1'b0);
                                end else if (r_bot == r_top) begin
                                    r_st <= S_OUT;
                                end else if (r_ph == P_TOP) begin
                                    r_st <= S_ISSUE;
                                    r_ph <= P_BOT; r_fix <= r_bot; r_pos <= r_lft;
                                    r_op <= mk(r_bot, r_lft, line_arms(1'b1, r_lft,
                                        r_lft, r_rgt), 1'b0);
                                end else begin
                                    r_st <= S_ISSUE;
                                    r_ph <= P_CORN; r_side2 <= 1'b0;
                                    r_op <= mk(r_top, r_lft, ARM_D, 1'b0);
                                end
                            end
                            P_CORN: begin
                                r_st <= S_ISSUE;
                                if (!r_side2) begin
                                    r_side2 <= 1'b1;
                                    r_op <= mk(r_top, r_rgt, ARM_D, 1'b0);
                                end else if (r_top + 12'sd1 < r_bot) begin
                                    r_ph <= P_SIDE; r_side2 <= 1'b0;
                                    r_pos <= r_top + 12'sd1;
                                    r_op <= mk(r_top + 12'sd1, r_lft, ARM_U | ARM_D, r_dw);
                                end else begin
                                    r_ph <= P_FOOT; r_side2 <= 1'b0;
                                    r_op <= mk(r_bot, r_lft, ARM_U, 1'b0);
                                end
                            end
                            P_SIDE: begin
                                r_st <= S_ISSUE;
                                if (!r_side2) begin
                                    r_side2 <= 1'b1;
                                    r_op <= mk(r_pos, r_rgt, ARM_U | ARM_D, r_dw);
                                end else if (r_pos + 12'sd1 < r_bot) begin
                                    r_side2 <= 1'b0;
                                    r_pos <= r_pos + 12'sd1;
                                    r_op <= mk(r_pos + 12'sd1, r_lft, ARM_U | ARM_D, r_dw);
                                end else begin
                                    r_ph <= P_FOOT; r_side2 <= 1'b0;
                                    r_op <= mk(r_bot, r_lft, ARM_U, 1'b0);
                                end
                            end
                            default: begin
                                if (!r_side2) begin
                                    r_st <= S_ISSUE;
                                    r_side2 <= 1'b1;
                                    r_op <= mk(r_bot, r_rgt, ARM_U, 1'b0);
                                end else r_st <= S_OUT;
                            end
                        endcase
                    end
                end
                default: if (!r_ovalid) begin
                    r_out <= {7'd0, 8'(e_wide), 7'(e_used),
                        (r_cmd == CMD_READ) ? e_rp : 1'b0,
                        (r_cmd == CMD_READ) ? e_rg : 16'd0,
                        (r_cmd > CMD_READ) ? 1'b0 : r_acc};
                    r_ovalid <= 1'b1;
                    r_st <= S_IDLE;
                end
            endcase
        end
    end
endmodule

[sv/bdgm_checker.sv]
// Port checker for the grid merger, bound to the top level.
`include "box_drawing_grid_merger_assert.svh"
module bdgm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    `BDGM_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `BDGM_ASSERT_IMP(a_known, i_clk, i_rst_n, m_axis_tvalid, !$isunknown(m_axis_tdata))
    `BDGM_ASSERT_NXT(a_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `BDGM_ASSERT_IMP(a_pad, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[39:33] == 7'd0)
endmodule

bind box_drawing_grid_merger bdgm_checker u_chk (.*);

[tb/box_drawing_grid_merger_test.sv]
// Self-checking testbench for the box-drawing grid merger: directed and random commands.
module box_drawing_grid_merger_test;
    import bdgm_pkg::*;

    localparam int NROWS = DefMaxRows;
    localparam int NCOLS = DefMaxCols;

    // One drawing command, in the order the fields are packed on the input stream.
    typedef struct {
        logic [2:0]         op;
        logic signed [11:0] row;
        logic signed [11:0] col;
        logic signed [11:0] row_end;
        logic signed [11:0] col_end;
        logic [15:0]        glyph;
        logic               dbl_walls;
        logic [1:0]         dir;
    } draw_cmd_t;

    // One status word from the output stream.
    typedef struct {
        logic        ok;
        logic [15:0] glyph;
        logic        present;
        logic [6:0]  lines;
        logic [7:0]  widest;
    } status_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [71:0]         s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [39:0]         m_axis_tdata;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [BudgetW-1:0]  i_cfg_data = '0;

    box_drawing_grid_merger dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the grid.
    logic [15:0] grid_glyph [NROWS][NCOLS];
    logic [3:0]  grid_arms [NROWS][NCOLS];
    logic        grid_dbl [NROWS][NCOLS];
    int          row_len [NROWS];
    int          rows_used;
    int          cells_taken;
    int          widest_row;
    int          budget;

    status_t     pending_status [$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // Arms that a line glyph stands for; zero for anything else.
    function automatic logic [3:0] glyph_arms(input logic [15:0] g);
        case (g)
            16'h2500: return ARM_L | ARM_R;
            16'h2502, 16'h2551: return ARM_U | ARM_D;
            16'h250C: return ARM_D | ARM_R;
            16'h2510: return ARM_D | ARM_L;
            16'h2514: return ARM_U | ARM_R;
            16'h2518: return ARM_U | ARM_L;
            16'h251C: return ARM_U | ARM_D | ARM_R;
            16'h2524: return ARM_U | ARM_D | ARM_L;
            16'h252C: return ARM_D | ARM_L | ARM_R;
            16'h2534: return ARM_U | ARM_L | ARM_R;
            16'h253C: return ARM_U | ARM_D | ARM_L | ARM_R;
            default: return 4'h0;
        endcase
    endfunction

    // Junction glyph drawn for a set of arms.
    function automatic logic [15:0] junction_glyph(input logic [3:0] a, input logic dbl);
        if (a == ARM_L || a == ARM_R || a == (ARM_L | ARM_R)) return 16'h2500;
        if (a == ARM_U || a == ARM_D || a == (ARM_U | ARM_D)) return dbl ? 16'h2551 : 16'h2502;
        case (a)
            ARM_D | ARM_R: return 16'h250C;
            ARM_D | ARM_L: return 16'h2510;
            ARM_U | ARM_R: return 16'h2514;
            ARM_U | ARM_L: return 16'h2518;
            ARM_U | ARM_D | ARM_R: return 16'h251C;
            ARM_U | ARM_D | ARM_L: return 16'h2524;
            ARM_D | ARM_L | ARM_R: return 16'h252C;
            ARM_U | ARM_L | ARM_R: return 16'h2534;
            4'hF: return 16'h253C;
            default: return GLYPH_SPACE;
        endcase
    endfunction

    // Grow the grid to cover a cell; false when caps or budget refuse it.
    function automatic bit grid_cover(input int r, input int c);
        int have;
        if (r < 0 || c < 0 || r >= NROWS || c >= NCOLS) return 0;
        have = (r < rows_used) ? row_len[r] : 0;
        if (c + 1 > have && cells_taken + (c + 1 - have) > budget) return 0;
        if (rows_used <= r) rows_used = r + 1;
        if (c + 1 > have) begin
            cells_taken += c + 1 - have;
            row_len[r] = c + 1;
            if (c + 1 > widest_row) widest_row = c + 1;
        end
        return 1;
    endfunction

    function automatic bit cell_write(input int r, input int c, input logic [15:0] g);
        if (!grid_cover(r, c)) return 0;
        grid_glyph[r][c] = g;
        grid_arms[r][c] = '0;
        grid_dbl[r][c] = 1'b0;
        return 1;
    endfunction

    // OR arms into a cell, leaving text cells alone.
    function automatic bit cell_join(input int r, input int c, input logic [3:0] a,
                                     input logic dbl_in);
        logic [3:0] cur;
        logic       dbl;
        if (!grid_cover(r, c)) return 0;
        cur = grid_arms[r][c];
        if (cur == 0) cur = glyph_arms(grid_glyph[r][c]);
        if (cur == 0 && grid_glyph[r][c] != GLYPH_SPACE) return 1;
        cur = cur | a;
        dbl = grid_dbl[r][c] | dbl_in;
        grid_glyph[r][c] = junction_glyph(cur, dbl);
        grid_arms[r][c] = cur;
        grid_dbl[r][c] = dbl;
        return 1;
    endfunction

    // A refused cell ends a horizontal line.
    function automatic bit draw_hline(input int r, input int a, input int b);
        int lo, hi;
        bit unused;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (lo == hi) return cell_join(r, lo, ARM_L | ARM_R, 1'b0);
        if (!cell_join(r, lo, ARM_R, 1'b0)) return 0;
        for (int c = lo + 1; c < hi; c++)
            if (!cell_join(r, c, ARM_L | ARM_R, 1'b0)) return 1;
        unused = cell_join(r, hi, ARM_L, 1'b0);
        return 1;
    endfunction

    // A refused cell is skipped by a vertical line.
    function automatic bit draw_vline(input int c, input int a, input int b);
        int lo, hi;
        bit first, unused;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (lo == hi) return cell_join(lo, c, ARM_U | ARM_D, 1'b0);
        first = cell_join(lo, c, ARM_D, 1'b0);
        for (int r = lo + 1; r < hi; r++) unused = cell_join(r, c, ARM_U | ARM_D, 1'b0);
        unused = cell_join(hi, c, ARM_U, 1'b0);
        return first;
    endfunction

    function automatic bit draw_box(input int t0, input int l0, input int b0, input int r0,
                                    input logic dw);
        int top, bot, lft, rgt;
        bit first, u;
        top = (b0 < t0) ? b0 : t0;
        bot = (b0 < t0) ? t0 : b0;
        lft = (r0 < l0) ? r0 : l0;
        rgt = (r0 < l0) ? l0 : r0;
        first = draw_hline(top, lft, rgt);
        if (bot > top) begin
            u = draw_hline(bot, lft, rgt);
            u = cell_join(top, lft, ARM_D, 1'b0);
            u = cell_join(top, rgt, ARM_D, 1'b0);
            for (int r = top + 1; r < bot; r++) begin
                u = cell_join(r, lft, ARM_U | ARM_D, dw);
                u = cell_join(r, rgt, ARM_U | ARM_D, dw);
            end
            u = cell_join(bot, lft, ARM_U, 1'b0);
            u = cell_join(bot, rgt, ARM_U, 1'b0);
        end
        return first;
    endfunction

    // Apply one command to the shadow grid and return the status it yields.
    function automatic status_t apply_cmd(input draw_cmd_t c);
        status_t s;
        int r, k;
        r = c.row;
        k = c.col;
        s = '{ok: 1'b0, glyph: '0, present: 1'b0, lines: '0, widest: '0};
        case (c.op)
            CMD_PUT: s.ok = cell_write(r, k, c.glyph);
            CMD_HLINE: s.ok = draw_hline(r, k, int'(c.col_end));
            CMD_VLINE: s.ok = draw_vline(k, r, int'(c.row_end));
            CMD_BOX: s.ok = draw_box(r, k, int'(c.row_end), int'(c.col_end), c.dbl_walls);
            CMD_ARROW: begin
                case (c.dir)
                    2'd0: s.ok = cell_write(r, k, 16'h25B2);
                    2'd1: s.ok = cell_write(r, k, 16'h25BC);
                    2'd2: s.ok = cell_write(r, k, 16'h25C4);
                    default: s.ok = cell_write(r, k, 16'h25BA);
                endcase
            end
            CMD_READ: begin
                if (r >= 0 && r < rows_used && k >= 0 && k < row_len[r]) begin
                    s.present = 1'b1;
                    s.glyph = grid_glyph[r][k];
                end
                s.ok = s.present;
            end
            default: ;
        endcase
        s.lines = rows_used[6:0];
        s.widest = widest_row[7:0];
        return s;
    endfunction

    // Send one command word; the prediction is taken when the word is accepted.
    task automatic send_cmd(input draw_cmd_t c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, c.dir, c.dbl_walls, c.glyph, c.col_end, c.row_end,
                         c.col, c.row, c.op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_status.push_back(apply_cmd(c));
        @(negedge i_clk);
    endtask

    task automatic send_fields(input logic [2:0] op, input int r, input int k, input int re,
                               input int ke, input logic [15:0] g, input logic dw,
                               input logic [1:0] d);
        draw_cmd_t c;
        c = '{op: op, row: r[11:0], col: k[11:0], row_end: re[11:0], col_end: ke[11:0],
              glyph: g, dbl_walls: dw, dir: d};
        send_cmd(c);
    endtask

    // Hold the sender until every expected status word has come back.
    task automatic drain_status();
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Write the cell budget while the block is idle.
    task automatic write_budget(input int value);
        drain_status();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value[BudgetW-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        budget = value & 16'h3FFF;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver side: random stalls, and every status word checked against the oldest prediction.
    always @(negedge i_clk) m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        status_t exp_s;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_status.size() == 0) begin
                $error("status word with none expected: %h", m_axis_tdata);
                error_count++;
            end else begin
                exp_s = pending_status.pop_front();
                if (m_axis_tdata[0] !== exp_s.ok) begin
                    $error("accepted: expected %0d, got %0d", exp_s.ok, m_axis_tdata[0]);
                    error_count++;
                end
                if (m_axis_tdata[16:1] !== exp_s.glyph) begin
                    $error("read_glyph: expected %h, got %h", exp_s.glyph, m_axis_tdata[16:1]);
                    error_count++;
                end
                if (m_axis_tdata[17] !== exp_s.present) begin
                    $error("cell_present: expected %0d, got %0d", exp_s.present,
                           m_axis_tdata[17]);
                    error_count++;
                end
                if (m_axis_tdata[24:18] !== exp_s.lines) begin
                    $error("line_count: expected %0d, got %0d", exp_s.lines,
                           m_axis_tdata[24:18]);
                    error_count++;
                end
                if (m_axis_tdata[32:25] !== exp_s.widest) begin
                    $error("widest_line: expected %0d, got %0d", exp_s.widest,
                           m_axis_tdata[32:25]);
                    error_count++;
                end
            end
        end
    end

    // Coordinate mostly inside the grid, sometimes negative, near the cap or anywhere.
    function automatic int pick_coord(input int span, input int cap, input bit wide);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 84) return $urandom_range(0, span);
        if (sel < 90) return -$urandom_range(1, 3);
        if (sel < 97 || !wide) return cap - 3 + $urandom_range(0, 5);
        return int'($signed(12'($urandom)));
    endfunction

    // Second end of a line or box, usually close to the first.
    function automatic int pick_end(input int start, input int cap);
        int sel;
        sel = $urandom_range(0, 199);
        if (sel == 0) return int'($signed(12'($urandom)));
        if (sel < 4) return $urandom_range(0, cap - 1);
        return start + $urandom_range(0, 12) - 4;
    endfunction

    function automatic logic [15:0] pick_glyph();
        logic [15:0] line_glyphs [12];
        line_glyphs = '{16'h2500, 16'h2502, 16'h2551, 16'h250C, 16'h2510, 16'h2514,
                        16'h2518, 16'h251C, 16'h2524, 16'h252C, 16'h2534, 16'h253C};
        case ($urandom_range(0, 3))
            0: return line_glyphs[$urandom_range(0, 11)];
            1: return GLYPH_SPACE;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count, input int row_span, input int col_span);
        draw_cmd_t c;
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 15) c.op = CMD_PUT;
            else if (sel < 30) c.op = CMD_HLINE;
            else if (sel < 45) c.op = CMD_VLINE;
            else if (sel < 60) c.op = CMD_BOX;
            else if (sel < 67) c.op = CMD_ARROW;
            else if (sel < 97) c.op = CMD_READ;
            else c.op = 3'($urandom_range(6, 7));
            // Only single-cell commands take coordinates from the whole field range.
            c.row = 12'(pick_coord(row_span, NROWS, c.op inside {CMD_PUT, CMD_ARROW, CMD_READ}));
            c.col = 12'(pick_coord(col_span, NCOLS, c.op inside {CMD_PUT, CMD_ARROW, CMD_READ}));
            c.row_end = 12'(pick_end(int'(c.row), NROWS));
            c.col_end = 12'(pick_end(int'(c.col), NCOLS));
            if (c.op == CMD_BOX && $urandom_range(0, 149) == 0) begin
                c.row = '0;
                c.col = '0;
                c.row_end = 12'(NROWS - 1);
                c.col_end = 12'(NCOLS - 1);
            end
            if (!(c.op inside {CMD_VLINE, CMD_BOX}) && $urandom_range(0, 3) == 0)
                c.row_end = 12'($urandom);
            if (!(c.op inside {CMD_HLINE, CMD_BOX}) && $urandom_range(0, 3) == 0)
                c.col_end = 12'($urandom);
            c.glyph = pick_glyph();
            c.dbl_walls = 1'($urandom);
            c.dir = 2'($urandom);
            send_cmd(c);
        end
    endtask

    // Single cells at the corners and past the caps, arrowheads, reads and unused codes.
    task automatic test_cells();
        send_fields(CMD_READ, 0, 0, 0, 0, 16'h0, 1'b0, 2'd0);
        send_fields(CMD_PUT, 0, 0, 0, 0, 16'hFFFF, 1'b1, 2'd3);
        send_fields(CMD_PUT, NROWS - 1, NCOLS - 1, -1, -1, 16'h0000, 1'b0, 2'd0);
        send_fields(CMD_PUT, NROWS, 0, 0, 0, 16'h0041, 1'b0, 2'd0);
        send_fields(CMD_PUT, 0, NCOLS, 0, 0, 16'h0041, 1'b0, 2'd0);
        send_fields(CMD_PUT, -2048, 2047, 2047, -2048, 16'h0041, 1'b0, 2'd0);
        for (int d = 0; d < 4; d++) send_fields(CMD_ARROW, 2, d, 0, 0, 16'h0, 1'b0, 2'(d));
        send_fields(CMD_READ, NROWS - 1, NCOLS - 1, 0, 0, 16'h0, 1'b0, 2'd0);
        send_fields(CMD_READ, 5, 200, 0, 0, 16'h0, 1'b0, 2'd0);
        send_fields(3'd6, 1, 1, 3, 3, 16'h0041, 1'b1, 2'd1);
        send_fields(3'd7, 1, 1, 3, 3, 16'h0041, 1'b1, 2'd1);
    endtask

    // Lines: reversed ends, single cells, text in the way, line glyphs to adopt,
    // and cells refused at the column or row cap.
    task automatic test_lines();
        send_fields(CMD_PUT, 4, 5, 0, 0, 16'h0058, 1'b0, 2'd0);
        send_fields(CMD_PUT, 4, 8, 0, 0, 16'h2502, 1'b0, 2'd0);
        send_fields(CMD_HLINE, 4, 10, 0, 2, 16'h0, 1'b0, 2'd0);
        send_fields(CMD_HLINE, 6, 3, 0, 3, 16'h0, 1'b0, 2'd0);
        send_fields(CMD_VLINE, 7, 3, 7, 0, 16'h0, 1'b0, 2'd0);
        send_fields(CMD_VLINE, 3, 6, -2, 0, 16'h0, 1'b0, 2'd0);
        send_fields(CMD_VLINE, NROWS - 2, 12, NROWS + 1, 0, 16'h0, 1'b0, 2'd0);
        send_fields(CMD_HLINE, 8, NCOLS - 3, 0, NCOLS + 2, 16'h0, 1'b0, 2'd0);
        send_fields(CMD_HLINE, 9, -1, 0, 4, 16'h0, 1'b0, 2'd0);
    endtask

    // Boxes with single and double walls, reversed corners and one flat row.
    task automatic test_boxes();
        send_fields(CMD_BOX, 10, 2, 14, 9, 16'h0, 1'b1, 2'd0);
        send_fields(CMD_BOX, 16, 8, 12, 4, 16'h0, 1'b0, 2'd0);
        send_fields(CMD_BOX, 18, 1, 18, 6, 16'h0, 1'b0, 2'd0);
        for (int r = 10; r <= 16; r++) send_fields(CMD_READ, r, 4, 0, 0, 16'h0, 1'b0, 2'd0);
    endtask

    // Budget just above use, at zero, below use and at the top of the register.
    task automatic test_budget();
        write_budget(cells_taken + 20);
        send_random(60, 30, 60);
        write_budget(0);
        send_random(50, 40, 80);
        write_budget(16383);
        send_random(100, 40, 100);
        write_budget(cells_taken / 2);
        send_random(50, 63, 127);
        write_budget(8192);
    endtask

    // Random traffic under each idling pattern.
    task automatic test_random();
        int modes_send [4];
        int modes_recv [4];
        modes_send = '{0, 63, 0, 31};
        modes_recv = '{0, 0, 63, 31};
        for (int m = 0; m < 4; m++) begin
            send_idle_pct = modes_send[m];
            recv_stall_pct = modes_recv[m];
            send_random(270, 20 + 14 * m, 40 + 28 * m);
        end
    endtask

    initial begin
        for (int r = 0; r < NROWS; r++) begin
            row_len[r] = 0;
            for (int c = 0; c < NCOLS; c++) begin
                grid_glyph[r][c] = GLYPH_SPACE;
                grid_arms[r][c] = '0;
                grid_dbl[r][c] = 1'b0;
            end
        end
        rows_used = 0;
        cells_taken = 0;
        widest_row = 0;
        budget = 8192;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_budget(8192);
        test_cells();
        test_lines();
        test_boxes();
        test_budget();
        test_random();

        drain_status();
        repeat (50) @(negedge i_clk);
        if (pending_status.size() != 0) begin
            $error("%0d status words never arrived", pending_status.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("box_drawing_grid_merger_test: done, clean");
        end else begin
            $display("box_drawing_grid_merger_test: done, errors");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #12000000;
        $display("box_drawing_grid_merger_test: done, errors");
        $finish;
    end
endmodule

[sim.f]
+incdir+sv
sv/bdgm_pkg.sv
sv/bdgm_cell_engine.sv
sv/box_drawing_grid_merger.sv
sv/bdgm_checker.sv
tb/box_drawing_grid_merger_test.sv
